### hw/rtl/rgbtp_pkg.sv
// ----------------------------------------------------------------------------
// rgbtp_pkg
// Shared types and character constants for the decimal RGB triplet parser.
// ----------------------------------------------------------------------------
package rgbtp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OVER    = 3'd1,
        ST_NODIGIT = 3'd2,
        ST_COMMA   = 3'd3,
        ST_EXTRA   = 3'd4
    } t_status;

    // Position within one component
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TRAIL  = 2'd2
    } t_phase;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COMP_W   = 8;
    localparam int unsigned IDX_W    = 2;
    // acc * 10 + 9 with acc <= 255 fits in 12 bits
    localparam int unsigned SUM_W    = 12;

    localparam logic [BYTE_W-1:0]  CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0]  CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0]  CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0]  CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0]  CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0]  CH_TAB   = 8'h09;

    localparam logic [SUM_W-1:0]   COMP_MAX = 12'd255;
    localparam logic [IDX_W-1:0]   IDX_LAST = 2'd2;

endpackage

### hw/rtl/rgb_triplet_text_parser.sv
// ----------------------------------------------------------------------------
// rgb_triplet_text_parser
// Streams text bytes and parses "r,g,b" decimal triplets, one result per
// zero-terminated string.
// ----------------------------------------------------------------------------
// One text byte is taken per clock. A byte passes through an input register,
// then updates the parse state while the parse result for a zero byte is
// written into the output register, from which the result is presented.
// Non-zero bytes keep flowing while a result waits to be taken; a
// terminator waits in the input register until the output register is
// free, so the input stalls only then.
module rgb_triplet_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: [7:0] text_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // tdata: [2:0] status, [10:3] red, [18:11] green, [26:19] blue, [31:27] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata
);
    import rgbtp_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Parse state
    logic [IDX_W-1:0]  r_idx,   n_idx;
    t_phase            r_phase, n_phase;
    logic [COMP_W-1:0] r_acc,   n_acc;
    logic [COMP_W-1:0] r_red,   n_red;
    logic [COMP_W-1:0] r_green, n_green;
    t_status           r_err,   n_err;

    // Output register
    logic                r_out_valid;
    t_status             r_out_status, n_out_status;
    logic [COMP_W-1:0]   r_out_red,    n_out_red;
    logic [COMP_W-1:0]   r_out_green,  n_out_green;
    logic [COMP_W-1:0]   r_out_blue,   n_out_blue;

    logic              is_nul, is_blank, is_digit, is_comma;
    logic              out_free, proc_go, in_take;
    logic [SUM_W-1:0]  acc_next;

    // Character classes
    assign is_nul   = (r_in_byte == CH_NUL);
    assign is_blank = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB);
    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign is_comma = (r_in_byte == CH_COMMA);

    // acc * 10 + digit as two shifts and two adds
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {8'h00, r_in_byte[3:0]};

    // Flow control: only a terminator needs the output register
    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc_go       = r_in_valid && (!is_nul || out_free);
    assign s_axis_tready = !r_in_valid || proc_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Parse step and result formation
    always_comb begin
        n_idx        = r_idx;
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_red        = r_red;
        n_green      = r_green;
        n_err        = r_err;
        n_out_status = ST_OK;
        n_out_red    = r_red;
        n_out_green  = r_green;
        n_out_blue   = r_acc;

        if (is_nul) begin
            // Final status, then back to the start of a string
            if (r_err != ST_OK) begin
                n_out_status = r_err;
            end else if (r_phase == PH_LEAD) begin
                n_out_status = ST_NODIGIT;
            end else if (r_idx < IDX_LAST) begin
                n_out_status = ST_COMMA;
            end
            if (n_out_status != ST_OK) begin
                n_out_red   = '0;
                n_out_green = '0;
                n_out_blue  = '0;
            end
            n_idx   = '0;
            n_phase = PH_LEAD;
            n_acc   = '0;
            n_red   = '0;
            n_green = '0;
            n_err   = ST_OK;
        end else if (r_err == ST_OK) begin
            unique case (r_phase)
                PH_LEAD, PH_DIGITS: begin
                    if (is_digit) begin
                        n_phase = PH_DIGITS;
                        if (acc_next > COMP_MAX) begin
                            n_err = ST_OVER;
                        end else begin
                            n_acc = acc_next[COMP_W-1:0];
                        end
                    end else if (is_blank) begin
                        // leading blanks are skipped, a blank after digits ends them
                        if (r_phase == PH_DIGITS) begin
                            n_phase = PH_TRAIL;
                        end
                    end else if (r_phase == PH_LEAD) begin
                        n_err = ST_NODIGIT;
                    end else if (r_idx >= IDX_LAST) begin
                        n_err = ST_EXTRA;
                    end else if (!is_comma) begin
                        n_err = ST_COMMA;
                    end else begin
                        if (r_idx == '0) begin
                            n_red = r_acc;
                        end else begin
                            n_green = r_acc;
                        end
                        n_idx   = r_idx + 1'b1;
                        n_phase = PH_LEAD;
                        n_acc   = '0;
                    end
                end
                default: begin
                    // trailing blanks
                    if (is_blank) begin
                        n_phase = r_phase;
                    end else if (is_digit || r_idx >= IDX_LAST) begin
                        n_err = (r_idx >= IDX_LAST) ? ST_EXTRA : ST_COMMA;
                    end else if (!is_comma) begin
                        n_err = ST_COMMA;
                    end else begin
                        if (r_idx == '0) begin
                            n_red = r_acc;
                        end else begin
                            n_green = r_acc;
                        end
                        n_idx   = r_idx + 1'b1;
                        n_phase = PH_LEAD;
                        n_acc   = '0;
                    end
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_phase <= PH_LEAD;
            r_acc   <= '0;
            r_red   <= '0;
            r_green <= '0;
            r_err   <= ST_OK;
        end else if (proc_go) begin
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_red   <= n_red;
            r_green <= n_green;
            r_err   <= n_err;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && is_nul) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && is_nul) begin
            r_out_status <= n_out_status;
            r_out_red    <= n_out_red;
            r_out_green  <= n_out_green;
            r_out_blue   <= n_out_blue;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_blue, r_out_green, r_out_red, r_out_status};

    // Checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
        (r_out_red == '0 && r_out_green == '0 && r_out_blue == '0))
        else $error("error result carries non-zero components");

    a_lead_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEAD) |-> (r_acc == '0))
        else $error("accumulator not clear before digits");

    a_term_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && is_nul) |=>
        (r_idx == '0 && r_phase == PH_LEAD && r_err == ST_OK && r_out_valid))
        else $error("terminator did not restart parse or raise result");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives zero-terminated text strings into rgb_triplet_text_parser and
// checks each parsed triplet and its status against a behavioural predictor.
// It uses a directed set of edge-case strings, then random mostly well-formed
// triplets with some corrupted ones and some noise.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rgbtp_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BYTES = 1650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // One parse result as carried on the result stream
    typedef struct packed {
        t_status                 status;
        logic [COMP_W-1:0]       red;
        logic [COMP_W-1:0]       green;
        logic [COMP_W-1:0]       blue;
    } t_triplet;

    // Receiver behaviour, changed every so often
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_SPARSE
    } t_sink_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;           // [2:0] status, [10:3] red,
                                                // [18:11] green, [26:19] blue

    logic [BYTE_W-1:0]  pending_bytes[$];
    t_triplet           expected_triplets[$];

    // Predictor state
    logic [IDX_W-1:0]   parse_idx;
    t_phase             parse_phase;
    logic [8:0]         parse_acc;
    logic [COMP_W-1:0]  parse_comp[3];
    t_status            parse_err;

    bit                 byte_taken = 1'b0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    t_sink_mode         sink_mode = SINK_OPEN;
    int                 sink_span = 0;
    int                 cycle_count = 0;
    int                 fail_count = 0;

    rgb_triplet_text_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock and reset
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic clear_parse_state();
        parse_idx   = '0;
        parse_phase = PH_LEAD;
        parse_acc   = '0;
        parse_err   = ST_OK;
        for (int k = 0; k < 3; k++) parse_comp[k] = '0;
    endtask

    // A finished component meets a byte that is neither blank nor digit
    task automatic close_component(input logic [BYTE_W-1:0] ch);
        if (parse_idx >= IDX_LAST) begin
            parse_err = ST_EXTRA;
        end else if (ch != CH_COMMA) begin
            parse_err = ST_COMMA;
        end else begin
            parse_comp[parse_idx] = parse_acc[7:0];
            parse_idx   = parse_idx + 1'b1;
            parse_phase = PH_LEAD;
            parse_acc   = '0;
        end
    endtask

    task automatic add_digit(input logic [BYTE_W-1:0] ch);
        logic [SUM_W-1:0] grown;
        grown = SUM_W'(parse_acc * 10 + (ch - CH_ZERO));
        if (grown > COMP_MAX)
            parse_err = ST_OVER;
        else
            parse_acc = grown[8:0];
    endtask

    task automatic parse_text_byte(input logic [BYTE_W-1:0] ch);
        t_triplet res;
        logic     blank;
        logic     digit;
        blank = (ch == CH_SPACE) || (ch == CH_TAB);
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        if (ch == CH_NUL) begin
            res = '0;
            res.status = parse_err;
            if (parse_err == ST_OK) begin
                if (parse_phase == PH_LEAD)
                    res.status = ST_NODIGIT;
                else if (parse_idx < IDX_LAST)
                    res.status = ST_COMMA;
            end
            if (res.status == ST_OK) begin
                res.red   = parse_comp[0];
                res.green = parse_comp[1];
                res.blue  = parse_acc[7:0];
            end
            expected_triplets.push_back(res);
            clear_parse_state();
        end else if (parse_err == ST_OK) begin
            if (parse_phase == PH_LEAD) begin
                if (digit) begin
                    parse_phase = PH_DIGITS;
                    add_digit(ch);
                end else if (!blank) begin
                    parse_err = ST_NODIGIT;
                end
            end else if (parse_phase == PH_DIGITS) begin
                if (digit)
                    add_digit(ch);
                else if (blank)
                    parse_phase = PH_TRAIL;
                else
                    close_component(ch);
            end else begin
                // trailing blanks
                if (digit)
                    parse_err = (parse_idx >= IDX_LAST) ? ST_EXTRA : ST_COMMA;
                else if (!blank)
                    close_component(ch);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) pending_bytes.push_back(s[k]);
        pending_bytes.push_back(CH_NUL);
    endtask

    function automatic string blank_run();
        string s;
        int    n;
        s = "";
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int k = 0; k < n; k++) s = {s, ($urandom_range(0, 1) == 1) ? " " : "\t"};
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: directed strings, then random ones
    // ------------------------------------------------------------------------
    initial begin : stimulus
        string s;
        string num;
        int    pos;
        int    n;
        logic [BYTE_W-1:0] junk;

        clear_parse_state();

        push_text("");                  // empty string
        push_text("0,0,0");
        push_text("255,255,255");
        push_text("256,0,0");           // overflow, rest ignored
        push_text(",1,2");              // comma before any digit
        push_text("7");                 // ends after first component
        push_text("1,2");               // ends after second component
        push_text("1 2,3");             // blank inside a number
        push_text("1,2,3 4");           // digit after third component
        push_text("1,2,3,4");           // comma after third component
        push_text("1;2,3");             // wrong separator
        push_text(" \t9 ,\t8\t, 7 \t");
        pending_bytes.push_back(8'hFF); // non-ASCII lead byte
        push_text(",1");
        pending_bytes.push_back(8'h80);
        push_text("");

        while (pending_bytes.size() < RANDOM_BYTES + 80) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: random non-zero bytes
                s = "";
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    junk = BYTE_W'($urandom_range(1, 255));
                    s = {s, " "};
                    s[s.len() - 1] = junk;
                end
            end else begin
                s = "";
                for (int k = 0; k < 3; k++) begin
                    case ($urandom_range(0, 9))
                        0:       num = $sformatf("%0d", $urandom_range(0, 9));
                        6:       num = $sformatf("%0d", $urandom_range(245, 255));
                        7:       num = $sformatf("%0d", $urandom_range(256, 99999));
                        8:       num = $sformatf("%04d", $urandom_range(0, 255));
                        default: num = $sformatf("%0d", $urandom_range(0, 255));
                    endcase
                    s = {s, blank_run(), num, blank_run()};
                    if (k < 2) s = {s, ","};
                end
                // corrupt about a quarter of the well-formed strings
                if ($urandom_range(0, 3) == 0 && s.len() > 0) begin
                    pos = $urandom_range(0, s.len() - 1);
                    case ($urandom_range(0, 3))
                        0: begin
                            junk = BYTE_W'($urandom_range(1, 255));
                            s[pos] = junk;
                        end
                        1: s = (pos == 0) ? "" : s.substr(0, pos - 1);
                        2: begin
                            if ($urandom_range(0, 1) == 1)
                                s = {s, blank_run(), "5"};
                            else
                                s = {s, blank_run(), ",9"};
                        end
                        default: s[pos] = " ";
                    endcase
                end
            end
            push_text(s);
        end

        // Wait for every byte to be taken and every result to be checked
        while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_triplets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Byte driver: bursts with random gaps, data held until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                s_axis_tdata  <= pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: ready pattern switches between modes
    always @(negedge i_clk) begin : result_sink
        if (sink_span == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_span = $urandom_range(32, 200);
        end else begin
            sink_span--;
        end
        case (sink_mode)
            SINK_OPEN:   m_axis_tready <= 1'b1;
            SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:     m_axis_tready <= ((sink_span % 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on accepted bytes, checks accepted results
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_triplet got;
        t_triplet want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        byte_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (byte_taken) parse_text_byte(s_axis_tdata);

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tdata[2:0]);
            got.red    = m_axis_tdata[10:3];
            got.green  = m_axis_tdata[18:11];
            got.blue   = m_axis_tdata[26:19];
            if (expected_triplets.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with none expected: status %0d rgb %0d,%0d,%0d",
                             $realtime, got.status, got.red, got.green, got.blue);
            end else begin
                want = expected_triplets.pop_front();
                if (got.status != want.status || got.red != want.red ||
                    got.green != want.green || got.blue != want.blue) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: mismatch: expected status %0d rgb %0d,%0d,%0d,",
                                  " got status %0d rgb %0d,%0d,%0d"},
                                 $realtime, want.status, want.red, want.green, want.blue,
                                 got.status, got.red, got.green, got.blue);
                end
            end
        end
    end

endmodule
